// ===== src/oks_pkg.sv =====
package oks_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int COUNT_W   = 7;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2
    } op_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                        add;
        logic                        remove;
        logic signed [KEY_WIDTH-1:0] new_key;
    } cmd_t;

endpackage

// ===== src/oks_cell.sv =====
module oks_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmp_en,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] cmp_key,
    input  oks_pkg::cmd_t                        cmd,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] left_key,
    input  logic                                 left_valid,
    input  logic                                 left_ge,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] right_key,
    input  logic                                 right_valid,
    output logic signed [oks_pkg::KEY_WIDTH-1:0] key_out,
    output logic                                 valid_out,
    output logic                                 ge_out,
    output logic                                 hit_out
);
    import oks_pkg::*;

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        ge_reg;
    logic                        hit_reg;

    // Cells at or after the request's position shift; on add the first one takes the new key.
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (cmd.add && ge_reg)
        begin
            if (left_ge)
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
            else
            begin
                key_next   = cmd.new_key;
                valid_next = 1'b1;
            end
        end
        else if (cmd.remove && ge_reg)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ge_reg    <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmp_en)
            begin
                ge_reg  <= !(valid_reg && (key_reg < cmp_key));
                hit_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign ge_out    = ge_reg;
    assign hit_out   = hit_reg;

endmodule

// ===== src/ordered_key_set_unit.sv =====
// Ordered key set: holds up to CAPACITY distinct signed keys in ascending order
// in a row of cells, each holding one key and handing it to a neighbor on a shift.
// Input channel: in_valid/in_stall carry one request word (opcode, key).
// Opcode add inserts the key, remove deletes it, contains looks it up.
// Output channel: out_valid/out_stall carry one result word per request
// (success, status, count).
// In the cycle a request is accepted every cell compares its key with the
// incoming key; once the output register is free the cells shift or hold and
// the result word is registered.
// One request is in flight at a time: a new word is taken only once the
// previous result has been registered.
// If the receiver stalls, the finished result waits in the output register,
// the next request may still be accepted and compared, and its update waits
// until the output register is free.
// Reset empties the store at once; no clearing pass is needed.
module ordered_key_set_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic signed [oks_pkg::KEY_WIDTH-1:0] key,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 success,
    output logic [1:0]                           status,
    output logic [oks_pkg::COUNT_W-1:0]          count
);
    import oks_pkg::*;

    logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
    logic signed [KEY_WIDTH-1:0] left_key   [CAPACITY];
    logic signed [KEY_WIDTH-1:0] right_key  [CAPACITY];
    logic [CAPACITY-1:0]         cell_valid;
    logic [CAPACITY-1:0]         cell_ge;
    logic [CAPACITY-1:0]         cell_hit;
    logic [CAPACITY-1:0]         left_valid;
    logic [CAPACITY-1:0]         left_ge;
    logic [CAPACITY-1:0]         right_valid;

    logic                        busy_reg;
    logic                        busy_next;
    logic [1:0]                  op_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        success_reg;
    logic                        success_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;

    logic   accept;
    logic   fire;
    logic   hit;
    logic   full;
    cmd_t   cmd;

    assign accept = in_valid && !in_stall;
    assign fire   = busy_reg && (!out_valid_reg || !out_stall);
    assign hit    = |cell_hit;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        cmd.add      = 1'b0;
        cmd.remove   = 1'b0;
        cmd.new_key  = key_reg;
        count_next   = count_reg;
        success_next = success_reg;
        status_next  = status_reg;
        if (fire)
        begin
            success_next = 1'b0;
            status_next  = ST_DONE;
            case (op_reg)
                OP_ADD:
                begin
                    if (hit)
                    begin
                        status_next = ST_MISS;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.add      = 1'b1;
                        success_next = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (hit)
                    begin
                        cmd.remove   = 1'b1;
                        success_next = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                OP_CONTAINS:
                begin
                    if (hit)
                    begin
                        success_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                default:
                begin
                    success_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        success_reg <= success_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_key[i]   = cell_key[i];
                assign left_valid[i] = 1'b1;
                assign left_ge[i]    = 1'b0;
            end
            else
            begin : g_mid_left
                assign left_key[i]   = cell_key[i-1];
                assign left_valid[i] = cell_valid[i-1];
                assign left_ge[i]    = cell_ge[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_key[i]   = cell_key[i];
                assign right_valid[i] = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_key[i]   = cell_key[i+1];
                assign right_valid[i] = cell_valid[i+1];
            end

            oks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmp_en      (accept),
                .cmp_key     (key),
                .cmd         (cmd),
                .left_key    (left_key[i]),
                .left_valid  (left_valid[i]),
                .left_ge     (left_ge[i]),
                .right_key   (right_key[i]),
                .right_valid (right_valid[i]),
                .key_out     (cell_key[i]),
                .valid_out   (cell_valid[i]),
                .ge_out      (cell_ge[i]),
                .hit_out     (cell_hit[i])
            );
        end
    endgenerate

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count exceeds capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("valid cells disagree with key count");

    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(cell_hit))
        else $error("key matched in more than one cell");

    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && success_reg) |-> (status_reg == ST_DONE))
        else $error("successful result with failure status");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted request not held");

endmodule
